### design/mswu_pkg.sv
package mswu_pkg;

    localparam int unsigned VAL_W    = 32;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned IN_IDX_W = 12;
    localparam int unsigned AG_W     = 49;
    localparam int unsigned MV_W     = 49;
    localparam int unsigned P_W      = 50;
    localparam int unsigned ACC_W    = 52;

    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned IDX_LSB   = 0;
    localparam int unsigned W_LSB     = 12;
    localparam int unsigned G_LSB     = 44;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [1:0] REG_MOMENTUM      = 2'd0;
    localparam logic [1:0] REG_LEARNING_RATE = 2'd1;
    localparam logic [1:0] REG_NESTEROV_MODE = 2'd2;

    localparam logic [COEF_W-1:0] MOMENTUM_RST      = 16'd58982;
    localparam logic [COEF_W-1:0] LEARNING_RATE_RST = 16'd655;
    localparam logic              NESTEROV_RST      = 1'b0;

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_BIAS   = 1'b1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0] SAT_HI  = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO  = {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_HALF = {{(ACC_W-FRAC_W){1'b0}}, 1'b1,
                                                    {(FRAC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    clip;
    } t_sat;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_weight;
        logic                    saturated;
    } t_result;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        logic signed [VAL_W-1:0] w;
        logic signed [AG_W-1:0]  ag;
    } t_front;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        logic signed [VAL_W-1:0] w;
        logic signed [VAL_W-1:0] vn;
        logic signed [MV_W-1:0]  mv;
        logic                    vflag;
        t_sat                    bias;
    } t_vel;

    function automatic t_sat f_sat(input logic signed [ACC_W-1:0] x);
        t_sat res;
        if (x > SAT_HI) begin
            res.value = VAL_MAX;
            res.clip  = 1'b1;
        end else if (x < SAT_LO) begin
            res.value = VAL_MIN;
            res.clip  = 1'b1;
        end else begin
            res.value = x[VAL_W-1:0];
            res.clip  = 1'b0;
        end
        return res;
    endfunction

    // round to nearest, ties up, then clamp
    function automatic t_sat f_round_sat(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] y;
        y = x + RND_HALF;
        y = y >>> FRAC_W;
        return f_sat(y);
    endfunction

endpackage

### design/mswu_front.sv
module mswu_front #(
    parameter int unsigned NUM_WEIGHTS = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic                                  i_kind,
    input  logic [mswu_pkg::IN_IDX_W-1:0]         i_index,
    input  logic signed [mswu_pkg::VAL_W-1:0]     i_weight,
    input  logic signed [mswu_pkg::VAL_W-1:0]     i_gradient,
    input  logic [mswu_pkg::COEF_W-1:0]           i_learning_rate,
    output mswu_pkg::t_front                      o_item,
    output logic [((NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1)-1:0] o_addr
);
    import mswu_pkg::*;

    localparam int unsigned IDX_W   = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int unsigned RCP_SH  = 24;
    localparam int unsigned RCP_W   = RCP_SH + 1;
    localparam int unsigned QP_W    = IN_IDX_W + RCP_W;
    localparam int unsigned QN_W    = 33;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RCP_SH) / NUM_WEIGHTS);

    // stage 1
    logic                     r_s1_valid;
    logic                     r_s1_kind;
    logic [IN_IDX_W-1:0]      r_s1_idx;
    logic signed [VAL_W-1:0]  r_s1_w;
    logic signed [VAL_W-1:0]  r_s1_g;

    // stage 2
    logic                     r_s2_valid;
    logic                     r_s2_kind;
    logic [IN_IDX_W-1:0]      r_s2_idx;
    logic [IN_IDX_W-1:0]      r_s2_q;
    logic signed [VAL_W-1:0]  r_s2_w;
    logic signed [AG_W-1:0]   r_s2_ag;

    // stage 3
    t_front                   r_s3;
    logic [IDX_W-1:0]         r_s3_addr;

    logic [QP_W-1:0]          q_prod;
    logic [IN_IDX_W-1:0]      n_s2_q;
    logic signed [AG_W-1:0]   n_s2_ag;
    logic [QN_W-1:0]          qn_prod;
    logic [IN_IDX_W-1:0]      rem_raw;
    logic [IN_IDX_W-1:0]      rem_fix;
    logic [IDX_W-1:0]         n_s3_addr;

    // quotient estimate by reciprocal, may be one short
    always_comb begin
        q_prod  = QP_W'(r_s1_idx) * QP_W'(RECIP);
        n_s2_q  = q_prod[RCP_SH +: IN_IDX_W];
        n_s2_ag = $signed({1'b0, i_learning_rate}) * r_s1_g;
    end

    always_comb begin
        qn_prod = QN_W'(r_s2_q) * QN_W'(NUM_WEIGHTS);
        rem_raw = IN_IDX_W'(QN_W'(r_s2_idx) - qn_prod);
        if (QN_W'(rem_raw) >= QN_W'(NUM_WEIGHTS)) begin
            rem_fix = IN_IDX_W'(QN_W'(rem_raw) - QN_W'(NUM_WEIGHTS));
        end else begin
            rem_fix = rem_raw;
        end
        n_s3_addr = IDX_W'(rem_fix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s1_kind  <= i_kind;
            r_s1_idx   <= i_index;
            r_s1_w     <= i_weight;
            r_s1_g     <= i_gradient;

            r_s2_valid <= r_s1_valid;
            r_s2_kind  <= r_s1_kind;
            r_s2_idx   <= r_s1_idx;
            r_s2_q     <= n_s2_q;
            r_s2_w     <= r_s1_w;
            r_s2_ag    <= n_s2_ag;

            r_s3.valid <= r_s2_valid;
            r_s3.kind  <= r_s2_kind;
            r_s3.w     <= r_s2_w;
            r_s3.ag    <= r_s2_ag;
            r_s3_addr  <= n_s3_addr;
        end
    end

    assign o_item = r_s3;
    assign o_addr = r_s3_addr;

endmodule

### design/mswu_velocity.sv
module mswu_velocity #(
    parameter int unsigned NUM_WEIGHTS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  mswu_pkg::t_front            i_item,
    input  logic [((NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1)-1:0] i_addr,
    input  logic [mswu_pkg::COEF_W-1:0] i_momentum,
    output mswu_pkg::t_vel              o_item,
    output logic                        o_clearing
);
    import mswu_pkg::*;

    localparam int unsigned IDX_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_WEIGHTS - 1);

    logic [VAL_W-1:0]         r_vel_mem [NUM_WEIGHTS];
    logic                     r_clearing;
    logic [IDX_W-1:0]         r_clr_addr;

    t_front                   r_s4;
    logic [IDX_W-1:0]         r_s4_addr;
    logic signed [VAL_W-1:0]  r_rd_data;

    t_vel                     r_s5;
    logic [IDX_W-1:0]         r_s5_addr;

    logic                     fwd;
    logic signed [VAL_W-1:0]  vp;
    logic signed [MV_W-1:0]   mv;
    logic signed [ACC_W-1:0]  vacc;
    logic signed [ACC_W-1:0]  bacc;
    t_sat                     vsat;
    t_sat                     bsat;
    logic                     wr_en;
    t_vel                     n_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // velocity multiply-accumulate, bypass from the item one stage ahead
    always_comb begin
        fwd   = r_s5.valid && (r_s5.kind == KIND_WEIGHT) && (r_s5_addr == r_s4_addr);
        vp    = fwd ? r_s5.vn : r_rd_data;
        mv    = $signed({1'b0, i_momentum}) * vp;
        vacc  = ACC_W'(mv) + ACC_W'(r_s4.ag);
        vsat  = f_round_sat(vacc);
        bacc  = (ACC_W'(r_s4.w) <<< FRAC_W) + ACC_W'(r_s4.ag);
        bsat  = f_round_sat(bacc);
        wr_en = i_en && r_s4.valid && (r_s4.kind == KIND_WEIGHT);

        n_s5.valid = r_s4.valid;
        n_s5.kind  = r_s4.kind;
        n_s5.w     = r_s4.w;
        n_s5.vn    = vsat.value;
        n_s5.mv    = mv;
        n_s5.vflag = vsat.clip;
        n_s5.bias  = bsat;
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_vel_mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            r_vel_mem[r_s4_addr] <= vsat.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data <= r_vel_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
            r_s5.valid <= 1'b0;
        end else if (i_en) begin
            r_s4      <= i_item;
            r_s4_addr <= i_addr;
            r_s5      <= n_s5;
            r_s5_addr <= r_s4_addr;
        end
    end

    assign o_item     = r_s5;
    assign o_clearing = r_clearing;

endmodule

### design/mswu_position.sv
module mswu_position (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  mswu_pkg::t_vel              i_item,
    input  logic [mswu_pkg::COEF_W-1:0] i_momentum,
    input  logic                        i_nesterov,
    output logic                        o_valid,
    output mswu_pkg::t_result           o_result
);
    import mswu_pkg::*;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        logic signed [VAL_W-1:0] w;
        logic signed [MV_W-1:0]  mv;
        logic signed [P_W-1:0]   p;
        t_sat                    plain;
        logic                    vflag;
        t_sat                    bias;
    } t_pos;

    t_pos                     r_s6;
    t_pos                     n_s6;
    logic signed [ACC_W-1:0]  nacc;
    t_sat                     nest;

    // (1 + mu) * v'
    always_comb begin
        n_s6.valid = i_item.valid;
        n_s6.kind  = i_item.kind;
        n_s6.w     = i_item.w;
        n_s6.mv    = i_item.mv;
        n_s6.p     = $signed({2'b01, i_momentum}) * i_item.vn;
        n_s6.plain = f_sat(ACC_W'(i_item.w) + ACC_W'(i_item.vn));
        n_s6.vflag = i_item.vflag;
        n_s6.bias  = i_item.bias;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.valid <= 1'b0;
        end else if (i_en) begin
            r_s6 <= n_s6;
        end
    end

    always_comb begin
        nacc = (ACC_W'(r_s6.w) <<< FRAC_W) - ACC_W'(r_s6.mv) + ACC_W'(r_s6.p);
        nest = f_round_sat(nacc);
        if (r_s6.kind == KIND_BIAS) begin
            o_result.new_weight = r_s6.bias.value;
            o_result.saturated  = r_s6.bias.clip;
        end else if (i_nesterov) begin
            o_result.new_weight = nest.value;
            o_result.saturated  = r_s6.vflag | nest.clip;
        end else begin
            o_result.new_weight = r_s6.plain.value;
            o_result.saturated  = r_s6.vflag | r_s6.plain.clip;
        end
    end

    assign o_valid = r_s6.valid;

endmodule

### design/mswu_out_queue.sv
module mswu_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mswu_pkg::t_result i_data,
    input  logic              i_ready,
    output logic              o_valid,
    output mswu_pkg::t_result o_data,
    output logic              o_full
);
    import mswu_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    t_result     r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_full  = (r_count == DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/momentum_sgd_weight_update.sv
// Momentum SGD weight updater. Every item accepted on the s_axis side gives exactly one result
// on m_axis, in order. Weight items read and rewrite the velocity kept for their index (index
// taken modulo NUM_WEIGHTS); bias items leave the velocities untouched. One item is taken per
// clock while the output queue is not full. The rate is set by the velocity multiply-accumulate
// stage, which takes a result of the same index from the item directly ahead through a bypass.
// A two-entry output queue lets the pipeline keep running while a result waits; s_axis_tready
// drops when that queue is full or while the velocity memory is cleared. After reset the
// velocity memory is zeroed one entry per cycle with s_axis_tready low; the APB port works
// during that time. Registers: 0x0 momentum (Q0.16), 0x4 learning rate (Q0.16), 0x8 nesterov
// mode (bit 0); change them only while no item is in flight.
module momentum_sgd_weight_update #(
    parameter int unsigned NUM_WEIGHTS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // weight_index, weight_value, gradient_value, zero pad
    input  logic [mswu_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // kind
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // new_weight
    output logic [mswu_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // saturated
    output logic [0:0]                          m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mswu_pkg::PADDR_W-1:0]        paddr,
    input  logic [mswu_pkg::PDATA_W-1:0]        pwdata,
    output logic [mswu_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import mswu_pkg::*;

    localparam int unsigned IDX_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

    logic [COEF_W-1:0]  r_momentum;
    logic [COEF_W-1:0]  r_learning_rate;
    logic               r_nesterov_mode;

    logic               en;
    logic               clearing;
    logic               q_full;
    logic               in_valid;
    t_front             front_item;
    logic [IDX_W-1:0]   front_addr;
    t_vel               vel_item;
    logic               pos_valid;
    t_result            pos_result;
    t_result            out_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_momentum      <= MOMENTUM_RST;
            r_learning_rate <= LEARNING_RATE_RST;
            r_nesterov_mode <= NESTEROV_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_MOMENTUM:      r_momentum      <= pwdata[COEF_W-1:0];
                REG_LEARNING_RATE: r_learning_rate <= pwdata[COEF_W-1:0];
                REG_NESTEROV_MODE: r_nesterov_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MOMENTUM:      prdata = PDATA_W'(r_momentum);
            REG_LEARNING_RATE: prdata = PDATA_W'(r_learning_rate);
            REG_NESTEROV_MODE: prdata = PDATA_W'(r_nesterov_mode);
            default:           prdata = '0;
        endcase
    end

    assign en            = !q_full;
    assign s_axis_tready = en && !clearing;
    assign in_valid      = s_axis_tvalid && !clearing;

    mswu_front #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (in_valid),
        .i_kind          (s_axis_tuser[0]),
        .i_index         (s_axis_tdata[IDX_LSB +: IN_IDX_W]),
        .i_weight        ($signed(s_axis_tdata[W_LSB +: VAL_W])),
        .i_gradient      ($signed(s_axis_tdata[G_LSB +: VAL_W])),
        .i_learning_rate (r_learning_rate),
        .o_item          (front_item),
        .o_addr          (front_addr)
    );

    mswu_velocity #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_velocity (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_item     (front_item),
        .i_addr     (front_addr),
        .i_momentum (r_momentum),
        .o_item     (vel_item),
        .o_clearing (clearing)
    );

    mswu_position u_position (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_item     (vel_item),
        .i_momentum (r_momentum),
        .i_nesterov (r_nesterov_mode),
        .o_valid    (pos_valid),
        .o_result   (pos_result)
    );

    mswu_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && pos_valid),
        .i_data  (pos_result),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_data),
        .o_full  (q_full)
    );

    assign m_axis_tdata = out_data.new_weight;
    assign m_axis_tuser = out_data.saturated;

endmodule

### design/mswu_checker.sv
module mswu_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [mswu_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input logic [0:0]                          m_axis_tuser
);
    // six pipeline stages plus two queue entries
    localparam logic [3:0] MAX_IN_FLIGHT = 4'd8;

    logic [3:0] r_pending;
    logic [3:0] n_pending;
    logic       s_xfer;
    logic       m_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_pending = r_pending;
        if (s_xfer && !m_xfer) begin
            n_pending = r_pending + 4'd1;
        end else if (m_xfer && !s_xfer) begin
            n_pending = r_pending - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 4'd0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken before velocity clear");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 4'd0)
        else $error("result without a pending item");

    a_in_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= MAX_IN_FLIGHT)
        else $error("too many items in flight");

endmodule

bind momentum_sgd_weight_update mswu_checker u_mswu_checker (.*);
